FILE: src/fgps_pkg.sv
// Shared types, constants and font lookup for the glyph pixel stream block.
package fgps_pkg;

  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  localparam logic       MODE_START   = 1'b0;
  localparam logic       MODE_ADVANCE = 1'b1;

  localparam int GLYPH_COUNT = 59;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd90;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       mode;
    logic [8:0] x_pos;
    logic [8:0] y_pos;
    logic [7:0] char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [1:0] scale;
  } fgps_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic       rejected;
  } fgps_rsp_t;

  typedef struct packed {
    logic        rejected;
    logic        last;
    logic        is_data;
    logic        pixel;
    logic [1:0]  comp;
    logic [15:0] value;
  } fgps_job_t;

  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543
  };

  function automatic logic [7:0] glyph_column(input logic [5:0] idx, input logic [2:0] col);
    logic [39:0] row;
    logic [7:0]  res;
    row = (idx < 6'(GLYPH_COUNT)) ? GLYPH_ROM[idx] : GLYPH_ROM[0];
    case (col)
      3'd0:    res = row[39:32];
      3'd1:    res = row[31:24];
      3'd2:    res = row[23:16];
      3'd3:    res = row[15:8];
      3'd4:    res = row[7:0];
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] color_channel(input logic [15:0] color, input logic [1:0] comp);
    logic [7:0] res;
    case (comp)
      COMP_RED:   res = {color[15:11], 3'b000};
      COMP_GREEN: res = {color[10:5], 2'b00};
      default:    res = {color[4:0], 3'b000};
    endcase
    return res;
  endfunction

endpackage

FILE: src/fgps_front.sv
// Front end: takes request words, tracks the stream position and issues byte jobs.
module fgps_front #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  fgps_pkg::fgps_req_t req,
  output logic                push,
  output fgps_pkg::fgps_job_t job
);
  import fgps_pkg::*;

  logic        busy;
  logic        in_pix;
  logic [3:0]  hdr_step;
  logic [1:0]  comp;
  logic        rep_c;
  logic [2:0]  fcol;
  logic        rep_r;
  logic [2:0]  frow;
  logic [5:0]  glyph;
  logic [15:0] held_fg;
  logic [15:0] held_bg;
  logic        s_two;
  logic [8:0]  held_x;
  logic [8:0]  held_y;

  logic [4:0]  req_w;
  logic [4:0]  req_h;
  logic        start_ok;
  logic        is_start;
  logic        is_adv;
  logic [9:0]  x1;
  logic [9:0]  y1;
  logic [7:0]  hdr_byte;
  logic        hdr_cmd;
  logic [7:0]  col_bits;
  logic        lit;
  logic        rep_c_end;
  logic        rep_r_end;
  logic        is_last;
  logic [7:0]  code;

  always_comb begin
    req_w    = {2'b00, req.scale, 1'b0} + {1'b0, req.scale, 2'b00};
    req_h    = {req.scale, 3'b000} - {3'b000, req.scale};
    start_ok = (req.scale == 2'd1 || req.scale == 2'd2) &&
               (11'(req.x_pos) + 11'(req_w) <= 11'(SCREEN_WIDTH)) &&
               (11'(req.y_pos) + 11'(req_h) <= 11'(SCREEN_HEIGHT));
    is_start = fire && (req.mode == MODE_START);
    is_adv   = fire && (req.mode == MODE_ADVANCE) && busy;
    code     = (req.char_code < FIRST_CODE || req.char_code > LAST_CODE) ?
               FIRST_CODE : req.char_code;

    x1 = {1'b0, held_x} + (s_two ? 10'd11 : 10'd5);
    y1 = {1'b0, held_y} + (s_two ? 10'd13 : 10'd6);

    hdr_cmd = 1'b0;
    case (hdr_step)
      4'd0: begin
        hdr_byte = CMD_COL_ADDR;
        hdr_cmd  = 1'b1;
      end
      4'd1: hdr_byte = {7'd0, held_x[8]};
      4'd2: hdr_byte = held_x[7:0];
      4'd3: hdr_byte = {6'd0, x1[9:8]};
      4'd4: hdr_byte = x1[7:0];
      4'd5: begin
        hdr_byte = CMD_ROW_ADDR;
        hdr_cmd  = 1'b1;
      end
      4'd6: hdr_byte = {7'd0, held_y[8]};
      4'd7: hdr_byte = held_y[7:0];
      4'd8: hdr_byte = {6'd0, y1[9:8]};
      4'd9: hdr_byte = y1[7:0];
      default: begin
        hdr_byte = CMD_MEM_WR;
        hdr_cmd  = 1'b1;
      end
    endcase

    col_bits  = glyph_column(glyph, fcol);
    lit       = (fcol != 3'd5) && col_bits[frow];
    rep_c_end = (rep_c == s_two);
    rep_r_end = (rep_r == s_two);
    is_last   = in_pix && frow == 3'd6 && rep_r_end && fcol == 3'd5 &&
                rep_c_end && comp == COMP_BLUE;

    push = (is_start && !start_ok) || is_adv;
    job  = '0;
    if (is_start) begin
      job.rejected = 1'b1;
      job.last     = 1'b1;
    end else if (in_pix) begin
      job.pixel   = 1'b1;
      job.is_data = 1'b1;
      job.comp    = comp;
      job.value   = lit ? held_fg : held_bg;
      job.last    = is_last;
    end else begin
      job.is_data = !hdr_cmd;
      job.value   = {8'd0, hdr_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      in_pix   <= 1'b0;
      hdr_step <= '0;
      comp     <= COMP_RED;
      rep_c    <= 1'b0;
      fcol     <= '0;
      rep_r    <= 1'b0;
      frow     <= '0;
      s_two    <= 1'b0;
    end else if (is_start) begin
      busy     <= start_ok;
      in_pix   <= 1'b0;
      hdr_step <= '0;
      comp     <= COMP_RED;
      rep_c    <= 1'b0;
      fcol     <= '0;
      rep_r    <= 1'b0;
      frow     <= '0;
      if (start_ok) begin
        s_two   <= (req.scale == 2'd2);
        glyph   <= 6'(code - FIRST_CODE);
        held_fg <= req.fg_color;
        held_bg <= req.bg_color;
        held_x  <= req.x_pos;
        held_y  <= req.y_pos;
      end
    end else if (is_adv) begin
      if (is_last) begin
        busy <= 1'b0;
      end
      if (!in_pix) begin
        if (hdr_step == 4'd10) begin
          in_pix <= 1'b1;
        end else begin
          hdr_step <= hdr_step + 4'd1;
        end
      end else if (comp != COMP_BLUE) begin
        comp <= comp + 2'd1;
      end else begin
        comp <= COMP_RED;
        if (!rep_c_end) begin
          rep_c <= 1'b1;
        end else begin
          rep_c <= 1'b0;
          if (fcol != 3'd5) begin
            fcol <= fcol + 3'd1;
          end else begin
            fcol <= '0;
            if (!rep_r_end) begin
              rep_r <= 1'b1;
            end else begin
              rep_r <= 1'b0;
              frow  <= frow + 3'd1;
            end
          end
        end
      end
    end
  end

endmodule

FILE: src/fgps_fifo.sv
// Short job queue between the front end and the output stage.
module fgps_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fgps_pkg::fgps_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output fgps_pkg::fgps_job_t head
);
  import fgps_pkg::*;

  fgps_job_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW + 1)'(QDEPTH))
    else $error("job queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("job queue count missed a write");
`endif

endmodule

FILE: src/fgps_back.sv
// Back end: turns queued jobs into display bytes and holds the result register.
module fgps_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  fgps_pkg::fgps_job_t head,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output fgps_pkg::fgps_rsp_t rsp
);
  import fgps_pkg::*;

  fgps_rsp_t rsp_next;

  always_comb begin
    pop               = !empty && (!rsp_valid || !rsp_stall);
    rsp_next.out_byte = head.pixel ? color_channel(head.value, head.comp) : head.value[7:0];
    rsp_next.is_data  = head.is_data;
    rsp_next.last     = head.last;
    rsp_next.rejected = head.rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: src/font_glyph_pixel_stream.sv
// Top level of the 5x7 glyph pixel stream generator.
// Each result word passes through a job queue entry and then the output register.
// One request word per cycle while req_stall is low; the four-entry job queue and the
// output register decouple the request side from the result side.
// A start word gives no result unless it is rejected; advance words when idle give none.
// Reset (synchronous, active high) clears the stream state, queue and output valid.
module font_glyph_pixel_stream #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  fgps_pkg::fgps_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output fgps_pkg::fgps_rsp_t rsp
);
  import fgps_pkg::*;

  logic      fire;
  logic      push;
  logic      full;
  logic      pop;
  logic      empty;
  fgps_job_t job;
  fgps_job_t head;

  assign req_stall = full;
  assign fire      = req_valid && !full;

  fgps_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .req (req),
    .push(push),
    .job (job)
  );

  fgps_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(job),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  fgps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule
